>>> sv/ehc_pkg.sv
// Shared types and constants for the energy histogram event classifier.
package ehc_pkg;

  // Histogram geometry (BIN_COUNT in 256..65536)
  localparam int BIN_COUNT = 16384;
  localparam int ADDR_W    = $clog2(BIN_COUNT);
  // Width that holds any energy or read index plus the bin count itself
  localparam int IDX_W     = 17;

  // Field widths
  localparam int ENERGY_W  = 16;
  localparam int FLAGS_W   = 32;
  localparam int RBIN_W    = 14;
  localparam int CNT_W     = 32;
  localparam int CLS_W     = 2;

  // Command queue between front and back (depth must be a power of two)
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // Item modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Event classes
  typedef enum logic [CLS_W-1:0] {
    CLS_NONE      = 2'd0,
    CLS_PILEUP    = 2'd1,
    CLS_SATURATED = 2'd2,
    CLS_CLEAN     = 2'd3
  } cls_t;

  // Decoded command handed from front to back
  typedef struct packed {
    logic              is_read;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    cls_t              cls;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOKUP
  } back_state_t;

endpackage

>>> sv/ehc_if.sv
// Input and output channel interfaces of the energy histogram event classifier.
interface ehc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ehc_pkg::ENERGY_W-1:0]  energy;
  logic [ehc_pkg::FLAGS_W-1:0]   flags;
  logic [ehc_pkg::RBIN_W-1:0]    read_bin;

  modport source (output valid, mode, energy, flags, read_bin, input ready);
  modport sink   (input valid, mode, energy, flags, read_bin, output ready);
endinterface

interface ehc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ehc_pkg::CNT_W-1:0]  bin_count;
  logic [ehc_pkg::CLS_W-1:0]  event_class;
  logic [ehc_pkg::CNT_W-1:0]  pileup_total;
  logic [ehc_pkg::CNT_W-1:0]  saturated_total;
  logic [ehc_pkg::CNT_W-1:0]  clean_total;
  logic [ehc_pkg::CNT_W-1:0]  overflow_total;

  modport source (output valid, bin_count, event_class, pileup_total, saturated_total,
                  clean_total, overflow_total, input ready);
  modport sink   (input valid, bin_count, event_class, pileup_total, saturated_total,
                  clean_total, overflow_total, output ready);
endinterface

>>> sv/ehc_front.sv
// Front end: accepts items, classifies flags and decodes the bin address.
module ehc_front (
  ehc_in_if.sink                in_ch,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  push,
  output ehc_pkg::cmd_t         cmd
);

  localparam logic [3:0] TOP_PILE_A = 4'hC;
  localparam logic [3:0] TOP_PILE_B = 4'h8;
  localparam logic [3:0] MID_SAT    = 4'h4;
  localparam logic [3:0] LOW_SAT    = 4'h8;
  localparam logic [3:0] TOP_CLEAN  = 4'h4;
  localparam logic [3:0] MID_CLEAN  = 4'h4;

  logic [3:0]                   top_nib;
  logic [3:0]                   mid_nib;
  logic [3:0]                   low_nib;
  ehc_pkg::cls_t                cls;
  logic [ehc_pkg::IDX_W-1:0]    energy_ext;
  logic [ehc_pkg::IDX_W-1:0]    rbin_ext;
  logic [ehc_pkg::IDX_W-1:0]    idx;

  // Flag classification, first match wins
  assign top_nib = in_ch.flags[15:12];
  assign mid_nib = in_ch.flags[11:8];
  assign low_nib = in_ch.flags[7:4];

  always_comb begin
    priority if (top_nib == TOP_PILE_A || top_nib == TOP_PILE_B) begin
      cls = ehc_pkg::CLS_PILEUP;
    end else if (mid_nib == MID_SAT || low_nib == LOW_SAT) begin
      cls = ehc_pkg::CLS_SATURATED;
    end else if (top_nib == TOP_CLEAN || mid_nib == MID_CLEAN) begin
      // mid test is shadowed by the saturated rule; kept as specified
      cls = ehc_pkg::CLS_CLEAN;
    end else begin
      cls = ehc_pkg::CLS_NONE;
    end
  end

  // Bin index and range check
  assign energy_ext = ehc_pkg::IDX_W'(in_ch.energy);
  assign rbin_ext   = ehc_pkg::IDX_W'(in_ch.read_bin);
  assign idx        = (in_ch.mode == ehc_pkg::MODE_READ) ? rbin_ext : energy_ext;

  always_comb begin
    cmd.is_read  = (in_ch.mode == ehc_pkg::MODE_READ);
    cmd.in_range = (idx < ehc_pkg::IDX_W'(ehc_pkg::BIN_COUNT));
    cmd.addr     = idx[ehc_pkg::ADDR_W-1:0];
    cmd.cls      = cmd.is_read ? ehc_pkg::CLS_NONE : cls;
  end

  // Handshake: hold off during the histogram clear and when the queue is full
  assign in_ch.ready = !q_full && !clearing;
  assign push        = in_ch.valid && in_ch.ready;

endmodule

>>> sv/ehc_fifo.sv
// Short command queue between the front and back ends.
module ehc_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ehc_pkg::cmd_t         push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  q_valid,
  output ehc_pkg::cmd_t         q_cmd
);

  ehc_pkg::cmd_t                entries [ehc_pkg::QDEPTH];
  logic [ehc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ehc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ehc_pkg::QPTR_W:0]     count;

  assign full    = (count == (ehc_pkg::QPTR_W+1)'(ehc_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/ehc_back.sv
// Back end: histogram memory read-modify-write, class counters, result register.
module ehc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ehc_pkg::cmd_t         q_cmd,
  output logic                  pop,
  output logic                  clearing,
  ehc_out_if.source             out_ch
);

  localparam logic [ehc_pkg::ADDR_W-1:0] LAST_BIN = ehc_pkg::ADDR_W'(ehc_pkg::BIN_COUNT - 1);
  localparam logic [ehc_pkg::CNT_W-1:0]  CNT_MAX  = '1;

  function automatic logic [ehc_pkg::CNT_W-1:0] sat_inc(input logic [ehc_pkg::CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  ehc_pkg::back_state_t         state;
  ehc_pkg::back_state_t         state_next;

  logic [ehc_pkg::CNT_W-1:0]    mem [ehc_pkg::BIN_COUNT];
  logic [ehc_pkg::CNT_W-1:0]    rd_data;
  logic                         mem_re;
  logic                         mem_we;
  logic [ehc_pkg::ADDR_W-1:0]   waddr;
  logic [ehc_pkg::CNT_W-1:0]    wdata;

  logic [ehc_pkg::ADDR_W-1:0]   clr_addr;
  ehc_pkg::cmd_t                cur;
  logic                         load_out;
  logic                         out_valid;

  logic [ehc_pkg::CNT_W-1:0]    pileup_cnt;
  logic [ehc_pkg::CNT_W-1:0]    saturated_cnt;
  logic [ehc_pkg::CNT_W-1:0]    clean_cnt;
  logic [ehc_pkg::CNT_W-1:0]    overflow_cnt;
  logic [ehc_pkg::CNT_W-1:0]    pileup_next;
  logic [ehc_pkg::CNT_W-1:0]    saturated_next;
  logic [ehc_pkg::CNT_W-1:0]    clean_next;
  logic [ehc_pkg::CNT_W-1:0]    overflow_next;
  logic [ehc_pkg::CNT_W-1:0]    bin_inc;
  logic [ehc_pkg::CNT_W-1:0]    count_val;
  logic                         rec;

  // Histogram memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[q_cmd.addr];
    end
  end

  // Item datapath
  assign rec       = !cur.is_read;
  assign bin_inc   = sat_inc(rd_data);
  assign count_val = !cur.in_range ? '0 : (cur.is_read ? rd_data : bin_inc);

  always_comb begin
    pileup_next    = pileup_cnt;
    saturated_next = saturated_cnt;
    clean_next     = clean_cnt;
    overflow_next  = overflow_cnt;
    if (rec) begin
      unique case (cur.cls)
        ehc_pkg::CLS_PILEUP:    pileup_next    = sat_inc(pileup_cnt);
        ehc_pkg::CLS_SATURATED: saturated_next = sat_inc(saturated_cnt);
        ehc_pkg::CLS_CLEAN:     clean_next     = sat_inc(clean_cnt);
        ehc_pkg::CLS_NONE:      ;
        default:                ;
      endcase
      if (!cur.in_range) begin
        overflow_next = sat_inc(overflow_cnt);
      end
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ehc_pkg::B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    waddr      = clr_addr;
    wdata      = '0;
    load_out   = 1'b0;
    clearing   = 1'b0;
    unique case (state)
      ehc_pkg::B_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
        if (clr_addr == LAST_BIN) begin
          state_next = ehc_pkg::B_IDLE;
        end
      end
      ehc_pkg::B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          mem_re     = 1'b1;
          state_next = ehc_pkg::B_LOOKUP;
        end
      end
      ehc_pkg::B_LOOKUP: begin
        if (!out_valid || out_ch.ready) begin
          load_out   = 1'b1;
          mem_we     = rec && cur.in_range;
          waddr      = cur.addr;
          wdata      = bin_inc;
          state_next = ehc_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ehc_pkg::B_CLEAR;
      end
    endcase
  end

  // Clear sweep address and current command
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ehc_pkg::B_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_cmd;
    end
  end

  // Counters and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pileup_cnt    <= '0;
      saturated_cnt <= '0;
      clean_cnt     <= '0;
      overflow_cnt  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        pileup_cnt    <= pileup_next;
        saturated_cnt <= saturated_next;
        clean_cnt     <= clean_next;
        overflow_cnt  <= overflow_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.bin_count       <= count_val;
      out_ch.event_class     <= cur.cls;
      out_ch.pileup_total    <= pileup_next;
      out_ch.saturated_total <= saturated_next;
      out_ch.clean_total     <= clean_next;
      out_ch.overflow_total  <= overflow_next;
    end
  end

  assign out_ch.valid = out_valid;

  // Checks
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ehc_pkg::B_CLEAR) |-> !out_valid)
    else $error("result valid during histogram clear");

  a_single_mem_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("histogram read and write in the same cycle");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ehc_pkg::B_LOOKUP))
    else $error("result appeared without a lookup");

  a_overflow_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (overflow_cnt >= $past(overflow_cnt)))
    else $error("overflow counter decreased");

endmodule

>>> sv/energy_histogram_event_classifier_top.sv
// Top level of the energy histogram event classifier.
// Each record item adds one count to the histogram bin chosen by its energy
// (saturating at all ones), or to the overflow counter when the energy is at or
// above ehc_pkg::BIN_COUNT, and bumps the pile-up, saturated or clean counter
// chosen by flag bits 15..4; a read item returns one bin and the counters
// unchanged. Every item gives exactly one result. The front end decodes items
// into a two-entry command queue, so input is taken while a result waits at the
// output. The back end handles each item on the histogram RAM (one write port,
// one registered read port) in order: B_IDLE pops the command and issues the
// registered read, then B_LOOKUP does the saturating increment, write-back and
// result load, waiting there while the output is stalled; a new item is taken
// only after that. After reset the RAM is cleared one bin per cycle, during
// which in_ch.ready stays low.
module energy_histogram_event_classifier_top (
  input  logic        clk,
  input  logic        rst,
  ehc_in_if.sink      in_ch,
  ehc_out_if.source   out_ch
);

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  logic               clearing;
  ehc_pkg::cmd_t      push_cmd;
  ehc_pkg::cmd_t      q_cmd;

  ehc_front u_front (
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  ehc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  ehc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
